// File: rtl/bfcba_pkg.sv
// Shared types and constants for the best-fit block allocator.
// No dependencies; imported by bfcba_alu and the allocator unit.
`default_nettype none
package bfcba_pkg;

   localparam int GRAN_SHIFT = 9;          // 512-byte granules
   localparam int SIZE_W     = 32;         // request size in bytes
   localparam int ADDR_W     = 40;         // address field width
   localparam int GRAN_W     = 31;         // block start / length in granules
   localparam int REQ_W      = 24;         // rounded request in granules
   localparam int ALU_W      = 32;

   localparam logic [GRAN_W-1:0] SMALL_GRAN = 31'd2048;    // 1 MiB
   localparam logic [GRAN_W-1:0] SMALL_SEG  = 31'd4096;    // 2 MiB
   localparam logic [GRAN_W-1:0] LARGE_SEG  = 31'd40960;   // 20 MiB
   localparam logic [GRAN_W-1:0] MID_LIMIT  = 31'd20480;   // 10 MiB
   localparam logic [GRAN_W-1:0] HEAP_RESET = 31'd2097152;

   typedef enum logic [1:0] {
      SLOT_UNUSED = 2'd0,
      SLOT_FREE   = 2'd1,
      SLOT_ALLOC  = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_UNKNOWN   = 2'd3
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   localparam logic ACTION_ALLOC = 1'b0;

endpackage
`default_nettype wire

// File: rtl/bfcba_ram.sv
// Block table storage: one write port, one registered read port.
// Uses no package items.
`default_nettype none
module bfcba_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 90
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/bfcba_alu.sv
// Shared add/subtract unit used by the allocator sequencer.
// Depends on bfcba_pkg.
`default_nettype none
module bfcba_alu
   import bfcba_pkg::*;
(
   input  wire alu_op_type       op,
   input  wire logic [ALU_W-1:0] a,
   input  wire logic [ALU_W-1:0] b,
   output logic [ALU_W-1:0]      y
);

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/best_fit_caching_block_allocator_unit.sv
// Best-fit block allocator with split and coalesce over a slot table.
// Scan: one slot per cycle through the single RAM read port; a free then walks and merges
// free neighbors on both sides. Throughput: one request at a time; the next is taken once
// the response register loads, and a stalled response holds the block until the register
// frees. Reset: synchronous; a clearing pass marks every slot unused before the first
// request is taken.
// Depends on bfcba_pkg, bfcba_ram, bfcba_alu.
`default_nettype none
module best_fit_caching_block_allocator_unit
   import bfcba_pkg::*;
#(
   parameter int MAX_BLOCKS   = 256,
   parameter int ADDRESS_BITS = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_action,
   input  wire logic [SIZE_W-1:0] req_request_size,
   input  wire logic [ADDR_W-1:0] req_free_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ADDR_W-1:0]      rsp_address,
   output logic [1:0]             rsp_status,
   input  wire logic              csr_wr_en,
   input  wire logic [GRAN_W-1:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'(({(ADDR_W + 1){1'b0}} | (41'd1 << ADDRESS_BITS)) - 41'd1);

   typedef struct packed {
      slot_state_type      st;
      logic [GRAN_W-1:0]   start;
      logic [GRAN_W-1:0]   len;
      logic [LINK_W-1:0]   left;
      logic [LINK_W-1:0]   right;
   } entry_type;

   typedef enum logic [15:0] {
      ST_CLEAR     = 16'b0000_0000_0000_0001,
      ST_IDLE      = 16'b0000_0000_0000_0010,
      ST_SCAN      = 16'b0000_0000_0000_0100,
      ST_DECIDE    = 16'b0000_0000_0000_1000,
      ST_MISS      = 16'b0000_0000_0001_0000,
      ST_SPLIT_ADD = 16'b0000_0000_0010_0000,
      ST_SPLIT_WR  = 16'b0000_0000_0100_0000,
      ST_TAKE      = 16'b0000_0000_1000_0000,
      ST_LEFT_RD   = 16'b0000_0001_0000_0000,
      ST_LEFT_CHK  = 16'b0000_0010_0000_0000,
      ST_RIGHT_RD  = 16'b0000_0100_0000_0000,
      ST_RIGHT_CHK = 16'b0000_1000_0000_0000,
      ST_FIX_RD    = 16'b0001_0000_0000_0000,
      ST_FIX_WR    = 16'b0010_0000_0000_0000,
      ST_FINISH    = 16'b0100_0000_0000_0000,
      ST_RESP      = 16'b1000_0000_0000_0000
   } state_type;

   function automatic logic is_link(logic [LINK_W-1:0] l);
      return l < NIL;
   endfunction

   // registers
   state_type          state_ff, state_in, fix_ret_ff, fix_ret_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pv_ff, pv_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic               found_ff, found_in;
   entry_type          best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]   u0_ff, u0_in, u1_ff, u1_in;
   logic               u0_ok_ff, u0_ok_in, u1_ok_ff, u1_ok_in;
   logic               split_ff, split_in, miss_ff, miss_in;
   logic [IDX_W-1:0]   split_idx_ff, split_idx_in;
   logic [GRAN_W-1:0]  cursor_ff, cursor_in, cursor_next_ff, cursor_next_in;
   logic [GRAN_W-1:0]  heap_ff, heap_in, tmp_start_ff, tmp_start_in;
   logic [IDX_W-1:0]   fix_idx_ff, fix_idx_in;
   logic [LINK_W-1:0]  fix_val_ff, fix_val_in;
   logic               action_ff, action_in, small_ff, small_in;
   logic               aligned_ff, aligned_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [GRAN_W-1:0]  gran_ff, gran_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in, rsp_address_ff, rsp_address_in;
   status_type         res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // table and ALU hookup
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   entry_type          ram_wr_data;
   logic [$bits(entry_type)-1:0] ram_rd_bits;
   entry_type          rd_e;
   alu_op_type         alu_op;
   logic [ALU_W-1:0]   alu_a, alu_b, alu_y;

   // derived values
   logic [GRAN_W-1:0]  req_g, seg;
   logic [12:0]        seg_units;
   logic [REQ_W:0]     req_round;
   logic               issuing, seg_split;

   bfcba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH($bits(entry_type))) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   bfcba_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   assign rd_e  = entry_type'(ram_rd_bits);
   assign req_g = GRAN_W'(req_ff);

   // segment size for a miss
   assign seg_units = {1'b0, req_ff[REQ_W-1:12]} + 13'(|req_ff[11:0]);
   always_comb begin
      if (small_ff) begin
         seg = SMALL_SEG;
      end else if (req_g <= MID_LIMIT) begin
         seg = LARGE_SEG;
      end else begin
         seg = {6'b0, seg_units, 12'b0};
      end
   end
   assign seg_split = seg > req_g;

   // request rounded to granules, zero taken as one
   assign req_round = {1'b0, 1'b0, req_request_size[SIZE_W-1:GRAN_SHIFT]}
                    + (REQ_W + 1)'(|req_request_size[GRAN_SHIFT-1:0]);

   // shared ALU operand select
   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         ST_SPLIT_ADD: begin
            alu_a = {1'b0, best_ff.start};
            alu_b = {1'b0, req_g};
         end
         ST_SPLIT_WR: begin
            alu_op = ALU_SUB;
            alu_a  = {1'b0, best_ff.len};
            alu_b  = {1'b0, req_g};
         end
         ST_MISS: begin
            alu_a = {1'b0, cursor_ff};
            alu_b = {1'b0, seg};
         end
         ST_LEFT_CHK: begin
            alu_a = {1'b0, rd_e.len};
            alu_b = {1'b0, best_ff.len};
         end
         ST_RIGHT_CHK: begin
            alu_a = {1'b0, best_ff.len};
            alu_b = {1'b0, rd_e.len};
         end
         default: ;
      endcase
   end

   assign issuing = cnt_ff < CNT_MAX;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      fix_ret_in     = fix_ret_ff;
      cnt_in         = cnt_ff;
      pv_in          = pv_ff;
      pidx_in        = pidx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      u0_in          = u0_ff;
      u1_in          = u1_ff;
      u0_ok_in       = u0_ok_ff;
      u1_ok_in       = u1_ok_ff;
      split_in       = split_ff;
      split_idx_in   = split_idx_ff;
      miss_in        = miss_ff;
      cursor_in      = cursor_ff;
      cursor_next_in = cursor_next_ff;
      heap_in        = csr_wr_en ? csr_wr_data : heap_ff;
      tmp_start_in   = tmp_start_ff;
      fix_idx_in     = fix_idx_ff;
      fix_val_in     = fix_val_ff;
      action_in      = action_ff;
      small_in       = small_ff;
      aligned_in     = aligned_ff;
      req_in         = req_ff;
      gran_in        = gran_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      case (state_ff)
         // mark every slot unused after reset
         ST_CLEAR: begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = cnt_ff[IDX_W-1:0];
            ram_wr_data.st = SLOT_UNUSED;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_MAX - 1'b1) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               action_in  = req_action;
               req_in     = (req_round == '0) ? REQ_W'(1) : req_round[REQ_W-1:0];
               small_in   = ((req_round == '0) ? 25'd1 : req_round) <= 25'(SMALL_GRAN);
               gran_in    = req_free_address[ADDR_W-1:GRAN_SHIFT];
               aligned_in = req_free_address[GRAN_SHIFT-1:0] == '0;
               cnt_in     = '0;
               pv_in      = 1'b0;
               found_in   = 1'b0;
               u0_ok_in   = 1'b0;
               u1_ok_in   = 1'b0;
               miss_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         // one slot read per cycle, compared in the cycle after its read
         ST_SCAN: begin
            pv_in   = issuing;
            pidx_in = cnt_ff[IDX_W-1:0];
            if (issuing) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (pv_ff) begin
               if (rd_e.st == SLOT_UNUSED) begin
                  if (!u0_ok_ff) begin
                     u0_in    = pidx_ff;
                     u0_ok_in = 1'b1;
                  end else if (!u1_ok_ff) begin
                     u1_in    = pidx_ff;
                     u1_ok_in = 1'b1;
                  end
               end
               if (action_ff == ACTION_ALLOC) begin
                  if (rd_e.st == SLOT_FREE && ((rd_e.len <= SMALL_GRAN) == small_ff) &&
                      rd_e.len >= req_g &&
                      (!found_ff || rd_e.len < best_ff.len ||
                       (rd_e.len == best_ff.len && rd_e.start < best_ff.start))) begin
                     found_in    = 1'b1;
                     best_in     = rd_e;
                     best_idx_in = pidx_ff;
                  end
               end else begin
                  if (aligned_ff && !found_ff && rd_e.st == SLOT_ALLOC &&
                      rd_e.start == gran_ff) begin
                     found_in    = 1'b1;
                     best_in     = rd_e;
                     best_idx_in = pidx_ff;
                  end
               end
               if (!issuing) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            res_addr_in = '0;
            if (action_ff != ACTION_ALLOC) begin
               if (found_ff) begin
                  best_in.st = SLOT_FREE;
                  state_in   = ST_LEFT_RD;
               end else begin
                  res_status_in = STATUS_UNKNOWN;
                  state_in      = ST_RESP;
               end
            end else if (found_ff) begin
               if (best_ff.len > req_g) begin
                  if (u0_ok_ff) begin
                     split_in     = 1'b1;
                     split_idx_in = u0_ff;
                     state_in     = ST_SPLIT_ADD;
                  end else begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end
               end else begin
                  split_in = 1'b0;
                  state_in = ST_TAKE;
               end
            end else begin
               state_in = ST_MISS;
            end
         end
         // carve a new segment from the cursor
         ST_MISS: begin
            if (alu_y > {1'b0, heap_ff}) begin
               res_status_in = STATUS_EXHAUSTED;
               state_in      = ST_RESP;
            end else if (!u0_ok_ff || (seg_split && !u1_ok_ff)) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_RESP;
            end else begin
               best_in        = '{st: SLOT_FREE, start: cursor_ff, len: seg,
                                  left: NIL, right: NIL};
               best_idx_in    = u0_ff;
               split_in       = seg_split;
               split_idx_in   = u1_ff;
               cursor_next_in = alu_y[GRAN_W-1:0];
               miss_in        = 1'b1;
               state_in       = seg_split ? ST_SPLIT_ADD : ST_TAKE;
            end
         end
         ST_SPLIT_ADD: begin
            tmp_start_in = alu_y[GRAN_W-1:0];
            state_in     = ST_SPLIT_WR;
         end
         // remainder becomes a free block right of the taken one
         ST_SPLIT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = split_idx_ff;
            ram_wr_data = '{st: SLOT_FREE, start: tmp_start_ff, len: alu_y[GRAN_W-1:0],
                            left: {1'b0, best_idx_ff}, right: best_ff.right};
            if (is_link(best_ff.right)) begin
               fix_idx_in = best_ff.right[IDX_W-1:0];
               fix_val_in = {1'b0, split_idx_ff};
               fix_ret_in = ST_TAKE;
               state_in   = ST_FIX_RD;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = best_idx_ff;
            ram_wr_data = '{st: SLOT_ALLOC, start: best_ff.start,
                            len: split_ff ? req_g : best_ff.len, left: best_ff.left,
                            right: split_ff ? {1'b0, split_idx_ff} : best_ff.right};
            if (miss_ff) begin
               cursor_in = cursor_next_ff;
            end
            res_addr_in   = {best_ff.start, {GRAN_SHIFT{1'b0}}} & ADDR_MASK;
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end
         // coalesce leftwards
         ST_LEFT_RD: begin
            if (is_link(best_ff.left)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = best_ff.left[IDX_W-1:0];
               state_in    = ST_LEFT_CHK;
            end else begin
               state_in = ST_RIGHT_RD;
            end
         end
         ST_LEFT_CHK: begin
            if (rd_e.st == SLOT_FREE) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = best_idx_ff;
               ram_wr_data    = best_ff;
               ram_wr_data.st = SLOT_UNUSED;
               best_in        = '{st: SLOT_FREE, start: rd_e.start,
                                  len: alu_y[GRAN_W-1:0], left: rd_e.left,
                                  right: best_ff.right};
               best_idx_in    = best_ff.left[IDX_W-1:0];
               if (is_link(best_ff.right)) begin
                  fix_idx_in = best_ff.right[IDX_W-1:0];
                  fix_val_in = best_ff.left;
                  fix_ret_in = ST_LEFT_RD;
                  state_in   = ST_FIX_RD;
               end else begin
                  state_in = ST_LEFT_RD;
               end
            end else begin
               state_in = ST_RIGHT_RD;
            end
         end
         // coalesce rightwards
         ST_RIGHT_RD: begin
            if (is_link(best_ff.right)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = best_ff.right[IDX_W-1:0];
               state_in    = ST_RIGHT_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RIGHT_CHK: begin
            if (rd_e.st == SLOT_FREE) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = best_ff.right[IDX_W-1:0];
               ram_wr_data    = rd_e;
               ram_wr_data.st = SLOT_UNUSED;
               best_in.len    = alu_y[GRAN_W-1:0];
               best_in.right  = rd_e.right;
               if (is_link(rd_e.right)) begin
                  fix_idx_in = rd_e.right[IDX_W-1:0];
                  fix_val_in = {1'b0, best_idx_ff};
                  fix_ret_in = ST_RIGHT_RD;
                  state_in   = ST_FIX_RD;
               end else begin
                  state_in = ST_RIGHT_RD;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         // rewrite a neighbor's left link
         ST_FIX_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = fix_idx_ff;
            state_in    = ST_FIX_WR;
         end
         ST_FIX_WR: begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = fix_idx_ff;
            ram_wr_data      = rd_e;
            ram_wr_data.left = fix_val_ff;
            state_in         = fix_ret_ff;
         end
         ST_FINISH: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = best_idx_ff;
            ram_wr_data   = best_ff;
            res_addr_in   = '0;
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end
         // hand the result to the output register
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fix_ret_ff   <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         u0_ok_ff     <= 1'b0;
         u1_ok_ff     <= 1'b0;
         split_ff     <= 1'b0;
         miss_ff      <= 1'b0;
         cursor_ff    <= '0;
         heap_ff      <= HEAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fix_ret_ff   <= fix_ret_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         u0_ok_ff     <= u0_ok_in;
         u1_ok_ff     <= u1_ok_in;
         split_ff     <= split_in;
         miss_ff      <= miss_in;
         cursor_ff    <= cursor_in;
         heap_ff      <= heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      u0_ff          <= u0_in;
      u1_ff          <= u1_in;
      split_idx_ff   <= split_idx_in;
      cursor_next_ff <= cursor_next_in;
      tmp_start_ff   <= tmp_start_in;
      fix_idx_ff     <= fix_idx_in;
      fix_val_ff     <= fix_val_in;
      action_ff      <= action_in;
      small_ff       <= small_in;
      aligned_ff     <= aligned_in;
      req_ff         <= req_in;
      gran_ff        <= gran_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a previous one is in progress");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_wr_en)
      else $error("block table written while idle");

   a_error_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_address == '0)
      else $error("error response with nonzero address");

   a_cursor_on_alloc: assert property (@(posedge clock) disable iff (reset)
      cursor_ff != $past(cursor_ff) |-> $past(state_ff) == ST_TAKE)
      else $error("segment cursor moved outside a segment carve");

endmodule
`default_nettype wire
